/* hdl/gbpd_pkg.sv */
// Package for the gated bin phase block: widths, constants, CORDIC angle table
// and the record types passed between the preparation stages, cells and queue.
// No dependencies.
`default_nettype none

package gbpd_pkg;

  localparam int SAMPLE_WIDTH  = 24;
  localparam int THR_W         = 24;
  localparam int CORDIC_STAGES = 24;
  localparam int STAGE_W       = $clog2(CORDIC_STAGES);

  // Normalize the larger part up to at least 2**NORM_EXP before the CORDIC.
  localparam int NORM_EXP = 40;
  localparam int SH_W     = $clog2(NORM_EXP + 1);
  localparam int MSB_W    = $clog2(SAMPLE_WIDTH);

  // Datapath widths: x/y hold the normalized vector plus CORDIC gain,
  // z holds the angle in units of 2**-24 degree.
  localparam int CW = NORM_EXP + 5;
  localparam int ZW = 35;

  localparam int SQ_W  = 2 * SAMPLE_WIDTH;
  localparam int PWR_W = SQ_W + 1;
  localparam int TSQ_W = 2 * THR_W;
  localparam int CMP_W = (PWR_W > TSQ_W) ? PWR_W : TSQ_W;

  localparam int PH_W        = 17;
  localparam int PHASE_LIMIT = 46080;
  localparam int ROUND_HALF  = 32768;
  localparam int ROUND_SHIFT = 16;
  localparam int RQ_W        = ZW - ROUND_SHIFT;

  localparam logic signed [ZW-1:0] DEG180 = ZW'(64'd3019898880);

  localparam int IN_TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PH_W + 7) / 8) * 8;

  localparam int QDEPTH = 32;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                 valid;
    logic                 supp;
    logic                 zero;
    logic                 last;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [PH_W-1:0] phase;
    logic                   supp;
    logic                   last;
  } result_t;

  // atan(2**-i) in units of 2**-24 degree
  function automatic logic signed [ZW-1:0] atan_deg(input logic [STAGE_W-1:0] i);
    logic signed [ZW-1:0] a;
    begin
      case (i)
        5'd0:  a = ZW'(754974720);
        5'd1:  a = ZW'(445687602);
        5'd2:  a = ZW'(235489088);
        5'd3:  a = ZW'(119537938);
        5'd4:  a = ZW'(60000934);
        5'd5:  a = ZW'(30029717);
        5'd6:  a = ZW'(15018523);
        5'd7:  a = ZW'(7509720);
        5'd8:  a = ZW'(3754917);
        5'd9:  a = ZW'(1877466);
        5'd10: a = ZW'(938734);
        5'd11: a = ZW'(469367);
        5'd12: a = ZW'(234684);
        5'd13: a = ZW'(117342);
        5'd14: a = ZW'(58671);
        5'd15: a = ZW'(29335);
        5'd16: a = ZW'(14668);
        5'd17: a = ZW'(7334);
        5'd18: a = ZW'(3667);
        5'd19: a = ZW'(1833);
        5'd20: a = ZW'(917);
        5'd21: a = ZW'(458);
        5'd22: a = ZW'(229);
        5'd23: a = ZW'(115);
        default: a = '0;
      endcase
      return a;
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/gbpd_prep.sv */
// Front end of the phase pipeline: half-plane fold, magnitude gate and
// normalizing shift, four register stages. Uses gbpd_pkg.
`default_nettype none

module gbpd_prep
  import gbpd_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] real_part,
  input  logic signed [SAMPLE_WIDTH-1:0] imag_part,
  input  logic                           last_bin,
  input  logic [THR_W-1:0]               threshold,
  output cordic_t                        dout
);

  // stage 1: captured input
  logic                           v1;
  logic signed [SAMPLE_WIDTH-1:0] re1;
  logic signed [SAMPLE_WIDTH-1:0] im1;
  logic                           last1;

  // stage 2: folded vector, squares, magnitude bits
  logic                         v2;
  logic signed [SAMPLE_WIDTH:0] x2;
  logic signed [SAMPLE_WIDTH:0] y2;
  logic signed [ZW-1:0]         z2;
  logic [SQ_W-1:0]              sq_re2;
  logic [SQ_W-1:0]              sq_im2;
  logic [TSQ_W-1:0]             thr_sq2;
  logic [SAMPLE_WIDTH-1:0]      mag2;
  logic                         zero2;
  logic                         last2;

  // stage 3: shift amount and gate decision
  logic                         v3;
  logic signed [SAMPLE_WIDTH:0] x3;
  logic signed [SAMPLE_WIDTH:0] y3;
  logic signed [ZW-1:0]         z3;
  logic [SH_W-1:0]              sh3;
  logic                         supp3;
  logic                         zero3;
  logic                         last3;

  logic                         neg1;
  logic signed [SAMPLE_WIDTH:0] re_ext;
  logic signed [SAMPLE_WIDTH:0] im_ext;
  logic signed [SAMPLE_WIDTH:0] re_abs;
  logic signed [SAMPLE_WIDTH:0] im_abs;
  logic [MSB_W-1:0]             msb2;
  logic [CMP_W-1:0]             power2;
  logic [CMP_W-1:0]             thr_cmp2;
  logic [CW-1:0]                x3_ext;
  logic [CW-1:0]                y3_ext;

  always_comb begin
    re_ext = {re1[SAMPLE_WIDTH-1], re1};
    im_ext = {im1[SAMPLE_WIDTH-1], im1};
    neg1   = re1[SAMPLE_WIDTH-1];
    re_abs = neg1 ? -re_ext : re_ext;
    im_abs = im1[SAMPLE_WIDTH-1] ? -im_ext : im_ext;
  end

  // position of the leading one of the larger part
  always_comb begin
    msb2 = '0;
    for (int i = 0; i < SAMPLE_WIDTH; i++) begin
      if (mag2[i]) begin
        msb2 = MSB_W'(i);
      end
    end
    power2   = CMP_W'(sq_re2) + CMP_W'(sq_im2);
    thr_cmp2 = CMP_W'(thr_sq2);
  end

  always_comb begin
    x3_ext = {{(CW-SAMPLE_WIDTH-1){x3[SAMPLE_WIDTH]}}, x3};
    y3_ext = {{(CW-SAMPLE_WIDTH-1){y3[SAMPLE_WIDTH]}}, y3};
  end

  always_ff @(posedge clk) begin
    re1   <= real_part;
    im1   <= imag_part;
    last1 <= last_bin;

    // left half plane: negate and start from +-180 degrees
    x2      <= re_abs;
    y2      <= neg1 ? -im_ext : im_ext;
    z2      <= neg1 ? (im1[SAMPLE_WIDTH-1] ? -DEG180 : DEG180) : '0;
    sq_re2  <= re_abs[SAMPLE_WIDTH-1:0] * re_abs[SAMPLE_WIDTH-1:0];
    sq_im2  <= im_abs[SAMPLE_WIDTH-1:0] * im_abs[SAMPLE_WIDTH-1:0];
    thr_sq2 <= threshold * threshold;
    mag2    <= re_abs[SAMPLE_WIDTH-1:0] | im_abs[SAMPLE_WIDTH-1:0];
    zero2   <= (re1 == '0) && (im1 == '0);
    last2   <= last1;

    x3    <= x2;
    y3    <= y2;
    z3    <= z2;
    sh3   <= SH_W'(NORM_EXP) - SH_W'(msb2);
    supp3 <= power2 < thr_cmp2;
    zero3 <= zero2;
    last3 <= last2;

    dout.x    <= x3_ext << sh3;
    dout.y    <= y3_ext << sh3;
    dout.z    <= z3;
    dout.supp <= supp3;
    dout.zero <= zero3;
    dout.last <= last3;

    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      v1         <= in_valid;
      v2         <= v1;
      v3         <= v2;
      dout.valid <= v3;
    end
  end

endmodule

`default_nettype wire

/* hdl/gbpd_cell.sv */
// One vectoring CORDIC cell: a rotation by +-atan(2**-stage) and one register.
// Uses gbpd_pkg for the record type and the angle table.
`default_nettype none

module gbpd_cell
  import gbpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [STAGE_W-1:0] stage,
  input  cordic_t            din,
  output cordic_t            dout
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] ang;
  cordic_t              nxt;

  always_comb begin
    // arithmetic shifts round toward minus infinity
    xs  = din.x >>> stage;
    ys  = din.y >>> stage;
    ang = atan_deg(stage);
    nxt = din;
    if (!din.y[CW-1] && (din.y != '0)) begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + ang;
    end else begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/gbpd_outq.sv */
// Result queue and credit counter: holds finished results while the output
// side stalls and admits an input only when a queue slot is reserved for it.
// Uses gbpd_pkg.
`default_nettype none

module gbpd_outq
  import gbpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_accept,
  output logic    in_ready,
  input  logic    wr_valid,
  input  result_t wr_data,
  output logic    rd_valid,
  input  logic    rd_ready,
  output result_t rd_data
);

  result_t         mem [QDEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QC_W-1:0] fill;
  logic [QC_W-1:0] inflight;
  logic            rd_accept;

  always_comb begin
    rd_valid  = fill != '0;
    rd_data   = mem[rd_ptr];
    rd_accept = rd_valid && rd_ready;
    in_ready  = inflight != QC_W'(QDEPTH);
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      inflight <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_accept) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill     <= fill + QC_W'(wr_valid) - QC_W'(rd_accept);
      // count every transaction from input acceptance until it leaves
      inflight <= inflight + QC_W'(in_accept) - QC_W'(rd_accept);
    end
  end

endmodule

`default_nettype wire

/* hdl/gated_bin_phase_degrees.sv */
// Gated bin phase: atan2(imag, real) in 1/256 degree through a 24-cell CORDIC.
// Path from input transaction to output tvalid: 4 front-end stages, 24 cells,
// rounding into the result queue. The 32-entry queue absorbs output stalls.
// Throughput: one bin per cycle while the queue has a slot free to reserve.
// Reset clears the pipeline valids, the queue and the threshold (to 0).
`default_nettype none

module gated_bin_phase_degrees
  import gbpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // real_part, imag_part
  input  logic                   s_tlast,  // last_bin
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // phase_deg, zero fill
  output logic                   m_tuser,  // suppressed
  output logic                   m_tlast,  // last_out
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [THR_W-1:0]       cfg_data  // magnitude_threshold
);

  logic [THR_W-1:0]       threshold;
  logic                   in_accept;
  cordic_t                chain [CORDIC_STAGES+1];
  cordic_t                tail;
  logic signed [ZW-1:0]   z_round;
  logic signed [RQ_W-1:0] rq;
  logic signed [PH_W-1:0] phase;
  result_t                res;
  result_t                head;

  localparam logic signed [RQ_W-1:0] RQ_MAX = RQ_W'(PHASE_LIMIT);
  localparam logic signed [RQ_W-1:0] RQ_MIN = -RQ_MAX;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  gbpd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_accept),
    .real_part (s_tdata[SAMPLE_WIDTH-1:0]),
    .imag_part (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .last_bin  (s_tlast),
    .threshold (threshold),
    .dout      (chain[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    gbpd_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .stage (STAGE_W'(i)),
      .din   (chain[i]),
      .dout  (chain[i+1])
    );
  end

  assign tail = chain[CORDIC_STAGES];

  // round to nearest, clamp to +-180 degrees, drop to zero when gated or when the input is zero
  always_comb begin
    z_round = tail.z + ZW'(ROUND_HALF);
    rq      = z_round[ZW-1:ROUND_SHIFT];
    if (rq > RQ_MAX) begin
      phase = PH_W'(RQ_MAX);
    end else if (rq < RQ_MIN) begin
      phase = PH_W'(RQ_MIN);
    end else begin
      phase = rq[PH_W-1:0];
    end
    res.phase = (tail.supp || tail.zero) ? '0 : phase;
    res.supp  = tail.supp;
    res.last  = tail.last;
  end

  gbpd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_ready  (s_tready),
    .wr_valid  (tail.valid),
    .wr_data   (res),
    .rd_valid  (m_tvalid),
    .rd_ready  (m_tready),
    .rd_data   (head)
  );

  assign m_tdata = {{(OUT_TDATA_W-PH_W){1'b0}}, head.phase};
  assign m_tuser = head.supp;
  assign m_tlast = head.last;

endmodule

`default_nettype wire

/* test/testbench.sv */
// Testbench for gated_bin_phase_degrees: streams bins through the block, predicts
// phase, gate flag and last flag for each accepted bin and checks every result.
// Depends on gbpd_pkg (hdl/gbpd_pkg.sv) and the block itself.
`timescale 1ns / 100ps

module testbench;
  import gbpd_pkg::*;

  typedef struct packed {
    logic                           last;
    logic signed [SAMPLE_WIDTH-1:0] im;
    logic signed [SAMPLE_WIDTH-1:0] re;
  } bin_t;

  localparam longint BIN_MAX    = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint BIN_MIN    = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam longint NORM_FLOOR = 64'sd1 <<< 40;
  localparam longint HALF_TURN  = 64'sd3019898880;
  localparam longint PHASE_MAX  = 64'sd46080;
  localparam int     IDLE_PCT   = 22;
  localparam int     REPORT_MAX = 10;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [THR_W-1:0]       cfg_data = '0;

  bin_t             bins_to_send[$];
  result_t          phases_due[$];
  bin_t             bin_on_bus;
  logic             bus_busy = 1'b0;
  logic             bin_taken = 1'b0;
  logic             cfg_done = 1'b0;
  logic             steady = 1'b0;
  logic [THR_W-1:0] thr_copy = '0;
  int               faults = 0;

  gated_bin_phase_degrees i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // atan(2^-k) in units of 2^-24 degree
  function automatic longint atan_step(input int k);
    case (k)
      0:  return 754974720;
      1:  return 445687602;
      2:  return 235489088;
      3:  return 119537938;
      4:  return 60000934;
      5:  return 30029717;
      6:  return 15018523;
      7:  return 7509720;
      8:  return 3754917;
      9:  return 1877466;
      10: return 938734;
      11: return 469367;
      12: return 234684;
      13: return 117342;
      14: return 58671;
      15: return 29335;
      16: return 14668;
      17: return 7334;
      18: return 3667;
      19: return 1833;
      20: return 917;
      21: return 458;
      22: return 229;
      23: return 115;
      default: return 0;
    endcase
  endfunction

  function automatic longint bin_phase(input longint re, input longint im);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint r;
    int     k;
    if (re == 0 && im == 0) return 0;
    x = re;
    y = im;
    z = 0;
    // fold the left half plane onto the right one
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    while (x < NORM_FLOOR && ((y < 0) ? -y : y) < NORM_FLOOR) begin
      x = x * 2;
      y = y * 2;
    end
    for (k = 0; k < CORDIC_STAGES; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(k);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(k);
      end
    end
    r = (z + ROUND_HALF) >>> ROUND_SHIFT;
    if (r > PHASE_MAX) r = PHASE_MAX;
    if (r < -PHASE_MAX) r = -PHASE_MAX;
    return r;
  endfunction

  function automatic result_t gated_phase(input bin_t b);
    result_t r;
    longint  re;
    longint  im;
    longint  thr;
    re = $signed(b.re);
    im = $signed(b.im);
    thr = thr_copy;
    r.supp = (re * re + im * im) < thr * thr;
    r.phase = r.supp ? '0 : PH_W'(bin_phase(re, im));
    r.last = b.last;
    return r;
  endfunction

  function automatic bin_t random_bin(input longint thr);
    bin_t   b;
    int     kind;
    int     w;
    longint t;
    longint a;
    longint c;
    kind = $urandom_range(0, 9);
    if (kind >= 8 && thr == 0) kind = 0;
    case (kind)
      4, 5: begin
        w = $urandom_range(1, 12);
        b.re = SAMPLE_WIDTH'(longint'($urandom_range(0, (1 << (w + 1)) - 1)) - (64'sd1 << w));
        b.im = SAMPLE_WIDTH'(longint'($urandom_range(0, (1 << (w + 1)) - 1)) - (64'sd1 << w));
      end
      6: begin
        b.re = SAMPLE_WIDTH'($urandom);
        b.im = SAMPLE_WIDTH'(longint'($urandom_range(0, 2)) - 1);
        if ($urandom_range(0, 1)) {b.re, b.im} = {b.im, b.re};
      end
      7: begin
        // close to the negative real axis, where the phase wraps
        b.re = SAMPLE_WIDTH'(-longint'($urandom_range(1, 8388608)));
        b.im = SAMPLE_WIDTH'(longint'($urandom_range(0, 6)) - 3);
      end
      8, 9: begin
        // land on or near the gate boundary
        t = (thr > BIN_MAX) ? BIN_MAX : thr;
        a = $urandom_range(0, t);
        c = longint'($floor($sqrt(real'(t * t - a * a)))) + longint'($urandom_range(0, 4)) - 2;
        if (c < 0) c = 0;
        if (c > BIN_MAX) c = BIN_MAX;
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) c = -c;
        if ($urandom_range(0, 1)) {a, c} = {c, a};
        b.re = SAMPLE_WIDTH'(a);
        b.im = SAMPLE_WIDTH'(c);
      end
      default: begin
        b.re = SAMPLE_WIDTH'($urandom);
        b.im = SAMPLE_WIDTH'($urandom);
      end
    endcase
    b.last = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  task automatic queue_bin(input longint re, input longint im, input logic last);
    bin_t b;
    b.re = SAMPLE_WIDTH'(re);
    b.im = SAMPLE_WIDTH'(im);
    b.last = last;
    bins_to_send.push_back(b);
  endtask

  task automatic queue_random(input int count);
    int n;
    for (n = 0; n < count; n++) bins_to_send.push_back(random_bin(thr_copy));
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (bins_to_send.size() != 0 || bus_busy || phases_due.size() != 0);
  endtask

  task automatic set_threshold(input longint value);
    wait_drained;
    cfg_valid <= 1'b1;
    cfg_data <= THR_W'(value);
    do @(negedge clk);
    while (!cfg_done);
    cfg_done = 1'b0;
    cfg_valid <= 1'b0;
  endtask

  // Driver: present bins from the pending queue, hold each until its transaction
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || bin_taken) begin
      bin_taken = 1'b0;
      if (bins_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        bin_on_bus = bins_to_send.pop_front();
        bus_busy = 1'b1;
        s_tdata <= {bin_on_bus.im, bin_on_bus.re};
        s_tlast <= bin_on_bus.last;
        s_tvalid <= 1'b1;
      end else begin
        bus_busy = 1'b0;
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && (steady || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: predict on each input transaction, check each output transaction
  always @(posedge clk) begin : watch
    result_t           due;
    logic signed [PH_W-1:0] got;
    int                diff;
    logic              bad;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        thr_copy = cfg_data;
        cfg_done = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        phases_due.push_back(gated_phase(bin_on_bus));
        bin_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[PH_W-1:0];
        if (phases_due.size() == 0) begin
          if (faults < REPORT_MAX)
            $display("unexpected result: phase %0d supp %b last %b", got, m_tuser, m_tlast);
          faults++;
        end else begin
          due = phases_due.pop_front();
          diff = int'(got) - int'(due.phase);
          // allow one unit of rounding slack on an ungated phase
          bad = $isunknown({m_tdata, m_tuser, m_tlast}) || m_tuser !== due.supp
                || m_tlast !== due.last || m_tdata[OUT_TDATA_W-1:PH_W] != '0
                || (due.supp ? got != '0 : (diff > 1 || diff < -1));
          if (bad) begin
            if (faults < REPORT_MAX)
              $display("mismatch: expected phase %0d supp %b last %b, got tdata %h supp %b last %b",
                       due.phase, due.supp, due.last, m_tdata, m_tuser, m_tlast);
            faults++;
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes and axes with the gate open (reset threshold)
    queue_bin(0, 0, 1'b0);
    queue_bin(BIN_MAX, 0, 1'b1);
    queue_bin(BIN_MIN, 0, 1'b0);
    queue_bin(-1, 0, 1'b1);
    queue_bin(0, BIN_MAX, 1'b0);
    queue_bin(0, BIN_MIN, 1'b0);
    queue_bin(0, 1, 1'b0);
    queue_bin(0, -1, 1'b1);
    queue_bin(1, 0, 1'b0);
    queue_bin(BIN_MAX, BIN_MAX, 1'b0);
    queue_bin(BIN_MIN, BIN_MIN, 1'b1);
    queue_bin(BIN_MIN, BIN_MAX, 1'b0);
    queue_bin(BIN_MAX, BIN_MIN, 1'b0);
    queue_bin(BIN_MIN, 1, 1'b0);
    queue_bin(BIN_MIN, -1, 1'b0);
    queue_bin(-1, -1, 1'b0);
    queue_bin(1, 1, 1'b0);
    queue_bin(-5, 1, 1'b1);
    wait_drained;

    // no idling on either side for this stretch
    steady = 1'b1;
    queue_random(200);
    wait_drained;
    steady = 1'b0;

    set_threshold((64'sd1 << THR_W) - 1);
    queue_bin(BIN_MIN, BIN_MIN, 1'b0);
    queue_bin(BIN_MAX, BIN_MAX, 1'b1);
    queue_random(60);

    set_threshold(1);
    queue_bin(0, 0, 1'b1);
    queue_bin(0, 1, 1'b0);
    queue_random(120);

    // both sides of an exact 3-4-5 boundary
    set_threshold(5);
    queue_bin(3, 4, 1'b0);
    queue_bin(3, 3, 1'b0);
    queue_bin(-4, -3, 1'b1);
    queue_bin(0, 5, 1'b0);
    queue_bin(0, -4, 1'b0);
    queue_bin(5, 0, 1'b0);
    queue_bin(-5, 0, 1'b1);
    queue_random(150);

    repeat (3) begin
      set_threshold($urandom_range(2, 8388607));
      queue_random(180);
    end

    set_threshold(0);
    queue_random(150);

    wait_drained;
    repeat (40) @(negedge clk);
    if (faults == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
